// ===== src/music_loudness_gain_ducker_top_macros.svh =====
// assertion macros for the music loudness gain ducker
`ifndef MUSIC_LOUDNESS_GAIN_DUCKER_TOP_MACROS_SVH
`define MUSIC_LOUDNESS_GAIN_DUCKER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define MLGD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlgd assertion failed");

// next-cycle implication, checked out of reset
`define MLGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlgd assertion failed");

`endif

// ===== src/mlgd_pkg.sv =====
// shared types and constants of the music loudness gain ducker
package mlgd_pkg;

   // event codes
   localparam logic [2:0] OP_LEVEL   = 3'd0;
   localparam logic [2:0] OP_TICK    = 3'd1;
   localparam logic [2:0] OP_START   = 3'd2;
   localparam logic [2:0] OP_STOP    = 3'd3;
   localparam logic [2:0] OP_SUSPEND = 3'd4;

   // stream run state codes
   localparam logic [1:0] RUN_STOPPED   = 2'd0;
   localparam logic [1:0] RUN_STARTED   = 2'd1;
   localparam logic [1:0] RUN_SUSPENDED = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_RAMP_EN   = 2'd1;
   localparam logic [1:0] CSR_RAMP_STEP = 2'd2;

   // write kinds
   localparam logic KIND_GAIN = 1'b0;
   localparam logic KIND_FADE = 1'b1;

   // magnitudes of an 8-bit signed level
   localparam int MAG_LEN = 129;

   // floor(1024 / 1.122^n), zero past the end
   localparam int ATTEN_LEN = 61;
   localparam logic [10:0] ATTEN_Q10 [ATTEN_LEN] = '{
      11'd1024, 11'd912, 11'd813, 11'd724, 11'd646, 11'd575, 11'd513, 11'd457,
      11'd407,  11'd363, 11'd323, 11'd288, 11'd257, 11'd229, 11'd204, 11'd182,
      11'd162,  11'd144, 11'd128, 11'd114, 11'd102, 11'd91,  11'd81,  11'd72,
      11'd64,   11'd57,  11'd51,  11'd45,  11'd40,  11'd36,  11'd32,  11'd28,
      11'd25,   11'd22,  11'd20,  11'd18,  11'd16,  11'd14,  11'd12,  11'd11,
      11'd10,   11'd9,   11'd8,   11'd7,   11'd6,   11'd5,   11'd5,   11'd4,
      11'd4,    11'd3,   11'd3,   11'd2,   11'd2,   11'd2,   11'd2,   11'd1,
      11'd1,    11'd1,   11'd1,   11'd1,   11'd1
   };

   typedef struct packed {
      logic signed [7:0] threshold_db;
      logic              ramp_enable;
      logic [6:0]        ramp_step;
   } cfg_type;

   typedef struct packed {
      logic        update_valid;
      logic        update_kind;
      logic [14:0] gain_value;
      logic        ramp_running;
      logic [10:0] target_level;
   } result_type;

endpackage

// ===== src/mlgd_core.sv =====
// gain state and single-pass event logic of the ducker
module mlgd_core import mlgd_pkg::*; #(
   parameter int DB_QUANTUM = 6,
   parameter int UNITY_GAIN = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [2:0]        opcode,
   input  logic signed [7:0] level_db,
   input  logic              anc_on,
   input  logic              stream_supported,
   input  cfg_type           cfg,
   output result_type        result
);

   localparam int GW = $clog2(UNITY_GAIN + 1);
   localparam logic [GW-1:0] UNITY = GW'(UNITY_GAIN);

   logic [1:0]        run_ff,  run_in;
   logic signed [7:0] last_ff, last_in;
   logic [GW-1:0]     app_ff,  app_in;
   logic [GW-1:0]     goal_ff, goal_in;
   logic              ramp_ff, ramp_in;

   // constant tables
   logic [7:0]    quant_rom [MAG_LEN];
   logic [GW-1:0] goal_rom  [ATTEN_LEN];

   for (genvar m = 0; m < MAG_LEN; m++) begin : g_quant
      assign quant_rom[m] = 8'((m / DB_QUANTUM) * DB_QUANTUM);
   end

   for (genvar i = 0; i < ATTEN_LEN; i++) begin : g_goal
      assign goal_rom[i] = GW'((32'(ATTEN_Q10[i]) * 32'(UNITY_GAIN)) >> 10);
   end

   // level quantization toward zero
   logic [7:0]        mag;
   logic [7:0]        qmag;
   logic signed [7:0] db_q;
   logic              above;
   logic [8:0]        n_diff;
   logic [GW-1:0]     goal_lut;

   always_comb begin
      mag    = level_db[7] ? 8'(-level_db) : 8'(level_db);
      qmag   = quant_rom[mag];
      if (level_db > cfg.threshold_db) begin
         db_q = level_db[7] ? signed'(8'(-qmag)) : signed'(qmag);
      end else begin
         db_q = level_db;
      end
      above  = db_q > cfg.threshold_db;
      n_diff = 9'({db_q[7], db_q}) - 9'({cfg.threshold_db[7], cfg.threshold_db});
      goal_lut = (n_diff < 9'(ATTEN_LEN)) ? goal_rom[n_diff[5:0]] : '0;
   end

   // ramp arithmetic
   logic [GW:0] up_sum;
   logic [GW:0] down_lim;

   assign up_sum   = {1'b0, app_ff} + (GW+1)'(cfg.ramp_step);
   assign down_lim = {1'b0, goal_ff} + (GW+1)'(cfg.ramp_step);

   logic        do_restore;
   logic        fade;
   logic        wr_valid;
   logic        wr_kind;
   logic [14:0] wr_value;

   always_comb begin
      run_in     = run_ff;
      last_in    = last_ff;
      app_in     = app_ff;
      goal_in    = goal_ff;
      ramp_in    = ramp_ff;
      do_restore = 1'b0;
      fade       = 1'b0;
      wr_valid   = 1'b0;
      wr_kind    = KIND_GAIN;
      wr_value   = '0;

      case (opcode)
         OP_LEVEL: begin
            if (run_ff == RUN_STARTED && anc_on && db_q != last_ff) begin
               last_in = db_q;
               if (above) begin
                  goal_in = goal_lut;
                  if (app_ff != goal_lut) begin
                     if (cfg.ramp_enable) begin
                        ramp_in = 1'b1;
                     end else begin
                        app_in = goal_lut;
                        fade   = 1'b1;
                     end
                  end
               end else begin
                  do_restore = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (ramp_ff) begin
               if (app_ff < goal_ff) begin
                  if (up_sum >= {1'b0, goal_ff}) begin
                     app_in  = goal_ff;
                     ramp_in = 1'b0;
                  end else begin
                     app_in = up_sum[GW-1:0];
                  end
               end else if (app_ff > goal_ff) begin
                  if ({1'b0, app_ff} <= down_lim) begin
                     app_in  = goal_ff;
                     ramp_in = 1'b0;
                  end else begin
                     app_in = app_ff - GW'(cfg.ramp_step);
                  end
               end else begin
                  ramp_in = 1'b0;
               end
               wr_valid = 1'b1;
               wr_kind  = KIND_GAIN;
               wr_value = 15'(app_in);
            end
         end
         OP_START: begin
            if (run_ff == RUN_STOPPED && stream_supported) begin
               app_in  = UNITY;
               goal_in = UNITY;
               last_in = 8'sd1;
               run_in  = RUN_STARTED;
            end
         end
         OP_STOP: begin
            if (run_ff == RUN_STARTED && stream_supported) begin
               do_restore = 1'b1;
               run_in     = RUN_STOPPED;
            end
         end
         OP_SUSPEND: begin
            do_restore = 1'b1;
            run_in     = RUN_SUSPENDED;
         end
         default: begin
         end
      endcase

      // back to unity gain
      if (do_restore && goal_ff != UNITY) begin
         goal_in = UNITY;
         ramp_in = 1'b0;
         last_in = 8'sd1;
         if (anc_on) begin
            if (app_ff != UNITY) begin
               if (cfg.ramp_enable) begin
                  ramp_in = 1'b1;
               end else begin
                  app_in = UNITY;
                  fade   = 1'b1;
               end
            end
         end else begin
            app_in = UNITY;
            fade   = !cfg.ramp_enable;
         end
      end

      if (fade) begin
         wr_valid = 1'b1;
         wr_kind  = KIND_FADE;
         wr_value = 15'({goal_in, 4'b0000});
      end

      result.update_valid = wr_valid;
      result.update_kind  = wr_kind;
      result.gain_value   = wr_value;
      result.ramp_running = ramp_in;
      result.target_level = 11'(goal_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= RUN_STOPPED;
         last_ff <= 8'sd1;
         app_ff  <= UNITY;
         goal_ff <= UNITY;
         ramp_ff <= 1'b0;
      end else if (advance) begin
         run_ff  <= run_in;
         last_ff <= last_in;
         app_ff  <= app_in;
         goal_ff <= goal_in;
         ramp_ff <= ramp_in;
      end
   end

endmodule

// ===== src/music_loudness_gain_ducker_top.sv =====
// top level of the music loudness gain ducker
// Dynamic gain limiter with a gain ramp for the feedback path of a noise
// canceller. Every transaction on the req_ channel (level, tick, stream start,
// stream stop, suspend) gives exactly one transaction on the rsp_ channel, in
// order. A level above threshold_db is cut toward zero to a multiple of
// DB_QUANTUM and looked up in a constant attenuation table to get the target
// gain; ticks walk the applied gain toward the target by ramp_step, or with
// ramp_enable low the target is written at once as a fade value (target << 4).
// One transaction is taken every clock unless rsp_ready stalls: an input
// register feeds a single pass of table lookup, compare and add, whose
// outcome lands in the result register together with the updated gain state.
// The result register parts the two sides, so req_ready stays high while a
// finished result waits as long as the input register can move. Registers
// are written through csr_ (index 0 threshold_db, 1 ramp_enable, 2
// ramp_step) and are meant to change only while the block is idle.
module music_loudness_gain_ducker_top import mlgd_pkg::*; #(
   parameter int DB_QUANTUM = 6,
   parameter int UNITY_GAIN = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // input events
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_opcode,
   input  logic signed [7:0] req_level_db,
   input  logic              req_anc_on,
   input  logic              req_stream_supported,
   // results
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_update_valid,
   output logic              rsp_update_kind,
   output logic [14:0]       rsp_gain_value,
   output logic              rsp_ramp_running,
   output logic [10:0]       rsp_target_level,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

`include "music_loudness_gain_ducker_top_macros.svh"

   // configuration registers, always ready
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_db <= 8'sd0;
         cfg_ff.ramp_enable  <= 1'b1;
         cfg_ff.ramp_step    <= 7'd5;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.threshold_db <= signed'(csr_wdata);
            CSR_RAMP_EN:   cfg_ff.ramp_enable  <= csr_wdata[0];
            CSR_RAMP_STEP: cfg_ff.ramp_step    <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   logic              in_valid_ff;
   logic [2:0]        in_opcode_ff;
   logic signed [7:0] in_level_ff;
   logic              in_anc_ff;
   logic              in_sup_ff;

   // result register
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;

   // the pending transaction moves when the result register is free or drains
   logic advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= req_opcode;
         in_level_ff  <= req_level_db;
         in_anc_ff    <= req_anc_on;
         in_sup_ff    <= req_stream_supported;
      end
   end

   // gain state update and result decode
   mlgd_core #(
      .DB_QUANTUM (DB_QUANTUM),
      .UNITY_GAIN (UNITY_GAIN)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .opcode           (in_opcode_ff),
      .level_db         (in_level_ff),
      .anc_on           (in_anc_ff),
      .stream_supported (in_sup_ff),
      .cfg              (cfg_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_update_valid = out_ff.update_valid;
   assign rsp_update_kind  = out_ff.update_kind;
   assign rsp_gain_value   = out_ff.gain_value;
   assign rsp_ramp_running = out_ff.ramp_running;
   assign rsp_target_level = out_ff.target_level;

   // checks
   `MLGD_ASSERT_IMPL(a_idle_write_zero, clock, reset, rsp_valid && !rsp_update_valid, !rsp_update_kind && rsp_gain_value == '0)
   `MLGD_ASSERT_IMPL(a_fade_aligned, clock, reset, rsp_valid && rsp_update_valid && rsp_update_kind == KIND_FADE, rsp_gain_value[3:0] == 4'd0)
   `MLGD_ASSERT_NEXT(a_pending_held, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule
